FILE: rtl/rtpfu_pkg.sv
// shared types, constants and codes for the h.264 fu-a depacketizer control unit
package rtpfu_pkg;

    // fixed port widths
    localparam int SEQ_W   = 16;
    localparam int TS_W    = 32;
    localparam int LEN_W   = 16;
    localparam int BYTE_W  = 8;

    // default for the number of length bits actually used
    localparam int LENGTH_BITS_DEF = 16;

    // nal unit types of interest
    localparam logic [4:0] NAL_IDR  = 5'd5;
    localparam logic [4:0] NAL_SPS  = 5'd7;
    localparam logic [4:0] NAL_PPS  = 5'd8;
    localparam logic [4:0] NAL_STAP = 5'd24;
    localparam logic [4:0] NAL_FU_A = 5'd28;

    // nal header masks
    localparam logic [7:0] NRI_MASK  = 8'hE0;
    localparam logic [7:0] TYPE_MASK = 8'h1F;

    // fu header bit positions
    localparam int FU_S_BIT = 7;
    localparam int FU_E_BIT = 6;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_DISCARD = 3'd1,
        ACT_APPEND  = 3'd2,
        ACT_START   = 3'd3,
        ACT_EMIT    = 3'd4,
        ACT_EMPTY   = 3'd5,
        ACT_SPS     = 3'd6,
        ACT_PPS     = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        FT_GENERIC = 2'd0,
        FT_P       = 2'd1,
        FT_I       = 2'd2
    } frame_type_t;

    // one packet descriptor
    typedef struct packed {
        logic [SEQ_W-1:0]  seq_number;
        logic              marker;
        logic [TS_W-1:0]   rtp_timestamp;
        logic [LEN_W-1:0]  payload_length;
        logic [LEN_W-1:0]  extension_length;
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
    } pkt_t;

    // one decision result
    typedef struct packed {
        action_t           action;
        logic              insert_param_sets;
        logic [BYTE_W-1:0] nal_header;
        logic [LEN_W-1:0]  data_offset;
        logic [LEN_W-1:0]  data_length;
        frame_type_t       frame_type;
        logic [TS_W-1:0]   frame_timestamp;
        logic [LEN_W-1:0]  extension_out;
    } res_t;

    // handshake between the input stage and the decision/output side
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

FILE: rtl/rtp_h264_fu_a_depacketizer_control_unit.sv
// top level of the h.264 fu-a depacketizer control unit
//
//  channel   dir  ports                              item
//  s_        in   s_valid / s_ready + 7 fields       one rtp packet descriptor
//  m_        out  m_valid / m_ready + 8 fields       one reassembly action
//
// every packet gives exactly one result; m_valid rises as it enters the result register
// one packet per cycle is sustained while m_ready stays high; the path is input register,
// decision logic, result register, with state updated as a packet leaves the input register
// reset (aresetn low at a clock edge) empties both registers and clears tracking state
// a stalled m_ready holds the result; an empty input register still takes one more transfer
module rtp_h264_fu_a_depacketizer_control_unit #(
    parameter int LENGTH_BITS = rtpfu_pkg::LENGTH_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rtpfu_pkg::SEQ_W-1:0]   s_seq_number,
    input  logic                          s_marker,
    input  logic [rtpfu_pkg::TS_W-1:0]    s_rtp_timestamp,
    input  logic [rtpfu_pkg::LEN_W-1:0]   s_payload_length,
    input  logic [rtpfu_pkg::LEN_W-1:0]   s_extension_length,
    input  logic [rtpfu_pkg::BYTE_W-1:0]  s_first_byte,
    input  logic [rtpfu_pkg::BYTE_W-1:0]  s_second_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_action,
    output logic                          m_insert_param_sets,
    output logic [rtpfu_pkg::BYTE_W-1:0]  m_nal_header,
    output logic [rtpfu_pkg::LEN_W-1:0]   m_data_offset,
    output logic [rtpfu_pkg::LEN_W-1:0]   m_data_length,
    output logic [1:0]                    m_frame_type,
    output logic [rtpfu_pkg::TS_W-1:0]    m_frame_timestamp,
    output logic [rtpfu_pkg::LEN_W-1:0]   m_extension_out
);
    import rtpfu_pkg::*;

    pkt_t       s_pkt;
    pkt_t       pkt;
    res_t       res;
    res_t       res_reg;
    logic       out_valid_reg;
    stage_ctl_t ctl;

    // gather input ports
    assign s_pkt.seq_number       = s_seq_number;
    assign s_pkt.marker           = s_marker;
    assign s_pkt.rtp_timestamp    = s_rtp_timestamp;
    assign s_pkt.payload_length   = s_payload_length;
    assign s_pkt.extension_length = s_extension_length;
    assign s_pkt.first_byte       = s_first_byte;
    assign s_pkt.second_byte      = s_second_byte;

    // move a packet on when the result register is free or being drained
    assign ctl.advance = ctl.valid && (!out_valid_reg || m_ready);

    rtpfu_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pkt     (s_pkt),
        .advance   (ctl.advance),
        .pkt_valid (ctl.valid),
        .pkt       (pkt)
    );

    rtpfu_decide #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (ctl.advance),
        .pkt     (pkt),
        .res     (res)
    );

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            res_reg <= res;
        end
    end

    // drive output ports
    assign m_valid             = out_valid_reg;
    assign m_action            = res_reg.action;
    assign m_insert_param_sets = res_reg.insert_param_sets;
    assign m_nal_header        = res_reg.nal_header;
    assign m_data_offset       = res_reg.data_offset;
    assign m_data_length       = res_reg.data_length;
    assign m_frame_type        = res_reg.frame_type;
    assign m_frame_timestamp   = res_reg.frame_timestamp;
    assign m_extension_out     = res_reg.extension_out;

endmodule

FILE: rtl/rtpfu_in_stage.sv
// input register stage for packet descriptors
module rtpfu_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rtpfu_pkg::pkt_t s_pkt,
    input  logic            advance,
    output logic            pkt_valid,
    output rtpfu_pkg::pkt_t pkt
);
    import rtpfu_pkg::*;

    logic valid_reg;
    pkt_t pkt_reg;

    // take a new transfer when empty or when the held item moves on
    assign s_ready   = !valid_reg || advance;
    assign pkt_valid = valid_reg;
    assign pkt       = pkt_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pkt_reg <= s_pkt;
        end
    end

endmodule

FILE: rtl/rtpfu_decide.sv
// loss tracking state and per-packet reassembly decision
module rtpfu_decide #(
    parameter int LENGTH_BITS = rtpfu_pkg::LENGTH_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  rtpfu_pkg::pkt_t pkt,
    output rtpfu_pkg::res_t res
);
    import rtpfu_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

    logic [SEQ_W-1:0] last_seq_reg;
    logic             have_last_seq_reg;
    logic             dropping_reg;
    logic             waiting_reg;
    logic             receiving_reg;
    frame_type_t      cur_ft_reg;

    logic             dropping_next;
    logic             waiting_next;
    logic             receiving_next;
    frame_type_t      cur_ft_next;

    logic [LB-1:0]    plen;
    logic [LB-1:0]    elen;
    logic [LB-1:0]    ext;
    logic [LB-1:0]    rem;
    logic [LB-1:0]    dlen;
    logic [LB:0]      off_sum;
    logic [LB-1:0]    doff;
    logic [4:0]       nal_type;
    logic [4:0]       fu_type;
    logic             fu_s;
    logic             fu_e;
    logic             gap;
    logic             drop_now;
    logic             wait_now;

    // length fields, trimmed to the used width
    assign plen    = pkt.payload_length[LB-1:0];
    assign elen    = pkt.extension_length[LB-1:0];
    assign ext     = (elen < plen) ? elen : plen;
    assign rem     = (plen > elen) ? (plen - elen) : '0;
    assign dlen    = (rem > LB'(2)) ? (rem - LB'(2)) : '0;
    assign off_sum = {1'b0, ext} + (LB+1)'(2);
    assign doff    = off_sum[LB] ? LEN_MAX : off_sum[LB-1:0];

    // header fields
    assign nal_type = pkt.first_byte[4:0];
    assign fu_type  = pkt.second_byte[4:0];
    assign fu_s     = pkt.second_byte[FU_S_BIT];
    assign fu_e     = pkt.second_byte[FU_E_BIT];

    // forward gap test, no wrap handling
    assign gap      = have_last_seq_reg &&
                      (({1'b0, last_seq_reg} + (SEQ_W+1)'(1)) < {1'b0, pkt.seq_number});
    assign drop_now = dropping_reg || gap;
    assign wait_now = waiting_reg || (gap && receiving_reg);

    // decision and next state
    always_comb begin
        res                 = '0;
        res.action          = ACT_NONE;
        res.frame_type      = FT_GENERIC;
        res.extension_out   = LEN_W'(ext);
        dropping_next       = drop_now;
        waiting_next        = wait_now;
        receiving_next      = receiving_reg;
        cur_ft_next         = cur_ft_reg;

        if (rem == '0) begin
            if (pkt.marker) begin
                res.action          = ACT_EMPTY;
                res.frame_timestamp = pkt.rtp_timestamp;
            end
        end else begin
            unique case (nal_type) inside
                [5'd1:5'd23]: begin
                    if (nal_type == NAL_IDR || nal_type == NAL_SPS || nal_type == NAL_PPS) begin
                        cur_ft_next = FT_I;
                    end else begin
                        cur_ft_next = FT_P;
                    end
                    if (nal_type == NAL_SPS || nal_type == NAL_PPS) begin
                        res.action      = (nal_type == NAL_SPS) ? ACT_SPS : ACT_PPS;
                        res.data_offset = LEN_W'(ext);
                        res.data_length = LEN_W'(rem);
                    end
                end
                NAL_FU_A: begin
                    if (fu_s) begin
                        dropping_next = 1'b0;
                        cur_ft_next   = FT_P;
                        if (fu_type == NAL_IDR || fu_type == NAL_SPS) begin
                            cur_ft_next           = FT_I;
                            waiting_next          = 1'b0;
                            receiving_next        = 1'b1;
                            res.insert_param_sets = 1'b1;
                        end
                        res.action      = ACT_START;
                        res.nal_header  = (pkt.first_byte & NRI_MASK) | {3'b000, fu_type};
                        res.data_offset = LEN_W'(doff);
                        res.data_length = LEN_W'(dlen);
                    end else if (drop_now || wait_now) begin
                        res.action = ACT_DISCARD;
                    end else begin
                        res.data_offset = LEN_W'(doff);
                        res.data_length = LEN_W'(dlen);
                        if (pkt.marker || fu_e) begin
                            res.action          = ACT_EMIT;
                            res.frame_type      = cur_ft_reg;
                            res.frame_timestamp = pkt.rtp_timestamp;
                        end else begin
                            res.action = ACT_APPEND;
                        end
                    end
                end
                default: begin
                    // reserved, aggregation and other fragment types are ignored
                end
            endcase
        end
    end

    // tracking state, updated once per processed packet
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg      <= '0;
            have_last_seq_reg <= 1'b0;
            dropping_reg      <= 1'b0;
            waiting_reg       <= 1'b0;
            receiving_reg     <= 1'b0;
            cur_ft_reg        <= FT_GENERIC;
        end else if (fire) begin
            last_seq_reg      <= pkt.seq_number;
            have_last_seq_reg <= 1'b1;
            dropping_reg      <= dropping_next;
            waiting_reg       <= waiting_next;
            receiving_reg     <= receiving_next;
            cur_ft_reg        <= cur_ft_next;
        end
    end

endmodule

FILE: rtl/rtpfu_checker.sv
// port-level checks for the depacketizer control unit, bound to the top level
module rtpfu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_action,
    input logic        m_insert_param_sets,
    input logic [15:0] m_data_offset,
    input logic [15:0] m_data_length,
    input logic [1:0]  m_frame_type,
    input logic [31:0] m_frame_timestamp
);
    import rtpfu_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_action)))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // parameter set insertion only on a fragment start
    a_ins_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_insert_param_sets) |-> (m_action == ACT_START))
        else $error("parameter set insertion outside fragment start");

    // discard and no-op carry no copy window and no timestamp
    a_discard_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_action == ACT_DISCARD || m_action == ACT_NONE)) |->
        (m_data_offset == '0 && m_data_length == '0 && m_frame_timestamp == '0))
        else $error("discard or no-op carries data fields");

    // a typed frame comes only with an emit
    a_type_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_type != FT_GENERIC) |-> (m_action == ACT_EMIT))
        else $error("frame type set without emit");

endmodule

bind rtp_h264_fu_a_depacketizer_control_unit rtpfu_checker u_rtpfu_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_action            (m_action),
    .m_insert_param_sets (m_insert_param_sets),
    .m_data_offset       (m_data_offset),
    .m_data_length       (m_data_length),
    .m_frame_type        (m_frame_type),
    .m_frame_timestamp   (m_frame_timestamp)
);
